FILE: rtl/core/tmi_pkg.sv
// package for the tape machine interpreter: widths, depths, opcodes, command bundles
// used by the datapath, controller, top level and testbench
package tmi_pkg;
  localparam int PROG_DEPTH  = 4096;
  localparam int TAPE_DEPTH  = 1024 * 8;
  localparam int INPUT_DEPTH = 256;
  localparam int PA_W = $clog2(PROG_DEPTH);
  localparam int TA_W = $clog2(TAPE_DEPTH);
  localparam int IA_W = $clog2(INPUT_DEPTH);
  localparam int PL_W = PA_W + 1;
  localparam int IL_W = IA_W + 1;

  localparam logic [1:0] FUNC_PROG = 2'd0;
  localparam logic [1:0] FUNC_INP  = 2'd1;
  localparam logic [1:0] FUNC_EXEC = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  // commands from controller to datapath
  typedef struct packed {
    logic prog_wr;     // append program byte
    logic inp_wr;      // append input byte
    logic prog_rd_scan;// read program at scan pointer
    logic prog_rd_next;// read program at pc+1 (lookahead)
    logic pc_inc;
    logic exec_cmd;    // apply command held in datapath
    logic comment_la;  // resolve '{' with lookahead byte
    logic scan_start;
    logic scan_step;   // consume scanned byte
    logic clr_step;
  } tmi_cmd_t;

  typedef struct packed {
    logic pc_at_end;
    logic next_at_end;  // pc+1 at or past length
    logic is_lbrace;
    logic is_jump;      // bracket whose jump is taken
    logic scan_empty;   // nothing to scan for the pending jump
    logic scan_done;
    logic clr_done;
  } tmi_sts_t;
endpackage

FILE: rtl/core/tmi_if.sv
// valid/ready channel interfaces for the tape machine interpreter
// no dependencies
interface tmi_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;
  modport source (output valid, func, data_byte, input ready);
  modport sink (input valid, func, data_byte, output ready);
endinterface

interface tmi_out_if;
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       halted;
  modport source (output valid, out_valid, out_byte, halted, input ready);
  modport sink (input valid, out_valid, out_byte, halted, output ready);
endinterface

FILE: rtl/core/tmi_ram.sv
// generic single-port ram with registered read
// no dependencies
module tmi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/core/tmi_datapath.sv
// datapath: program, tape and input memories, pointers, comment flag, bracket scanner
// depends on tmi_pkg and tmi_ram
module tmi_datapath (
  input  logic              clk,
  input  logic              rst,
  input  tmi_pkg::tmi_cmd_t cmd,
  input  logic [7:0]        data_byte,
  output tmi_pkg::tmi_sts_t sts,
  output logic              emit,
  output logic [7:0]        emit_byte
);
  import tmi_pkg::*;

  logic [PL_W-1:0] prog_len, pc, scan_p;
  logic [TA_W-1:0] tp;
  logic [IL_W-1:0] inp_cnt, inp_idx;
  logic            in_comment;
  logic [7:0]      cur;        // command being executed
  logic            scan_fwd;
  logic [PL_W:0]   depth;
  logic [TA_W-1:0] clr_addr;

  logic [PA_W-1:0] p_addr;
  logic            p_we;
  logic [7:0]      p_q;
  logic [TA_W-1:0] t_addr;
  logic            t_we;
  logic [7:0]      t_wd, t_q;
  logic [IA_W-1:0] i_addr;
  logic            i_we;
  logic [7:0]      i_q;

  assign p_we = cmd.prog_wr && (prog_len < PL_W'(PROG_DEPTH));
  assign i_we = cmd.inp_wr && (inp_cnt < IL_W'(INPUT_DEPTH));

  always_comb begin
    priority if (cmd.prog_wr) p_addr = prog_len[PA_W-1:0];
    else if (cmd.prog_rd_scan) p_addr = scan_p[PA_W-1:0];
    else if (cmd.prog_rd_next) p_addr = PA_W'(pc + PL_W'(1));
    else p_addr = pc[PA_W-1:0];
  end
  assign i_addr = i_we ? inp_cnt[IA_W-1:0] : inp_idx[IA_W-1:0];
  assign t_addr = cmd.clr_step ? clr_addr : tp;

  tmi_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(data_byte), .rdata(p_q));
  tmi_ram #(.WIDTH(8), .DEPTH(INPUT_DEPTH)) u_inp (
    .clk(clk), .we(i_we), .addr(i_addr), .wdata(data_byte), .rdata(i_q));
  tmi_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wd), .rdata(t_q));

  // current command decode, p_q holds it in the exec cycle
  logic live;
  assign live = !in_comment;
  always_comb begin
    t_we = cmd.clr_step;
    t_wd = 8'd0;
    if (cmd.exec_cmd && live) begin
      unique case (p_q)
        CH_PLUS:  begin t_we = 1'b1; t_wd = t_q + 8'd1; end
        CH_MINUS: begin t_we = 1'b1; t_wd = t_q - 8'd1; end
        CH_COMMA: begin t_we = 1'b1; t_wd = (inp_idx < inp_cnt) ? i_q : 8'd0; end
        default: ;
      endcase
    end
  end

  assign emit      = cmd.exec_cmd && live && (p_q == CH_DOT);
  assign emit_byte = t_q;

  assign sts.pc_at_end  = pc >= prog_len;
  assign sts.next_at_end = (pc + PL_W'(1)) >= prog_len;
  assign sts.is_lbrace  = p_q == CH_LBRACE;
  assign sts.is_jump    = live && ((p_q == CH_OPEN && t_q == 8'd0) ||
                                   (p_q == CH_CLOSE && t_q != 8'd0));
  // '[' as last byte or ']' as first byte has no range to scan
  assign sts.scan_empty = (cur == CH_OPEN) ? (pc >= prog_len) : (pc == PL_W'(1));
  assign sts.clr_done   = clr_addr == TA_W'(TAPE_DEPTH - 1);
  // scan finishes on a match or at an edge
  logic sc_hit;
  assign sc_hit = scan_fwd ? (p_q == CH_CLOSE && depth == (PL_W+1)'(1))
                           : (p_q == CH_OPEN && depth == (PL_W+1)'(1));
  assign sts.scan_done = sc_hit ||
                         (scan_fwd ? (scan_p + PL_W'(1) >= prog_len) : (scan_p == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      prog_len   <= '0;
      pc         <= '0;
      tp         <= TA_W'(TAPE_DEPTH / 2);
      inp_cnt    <= '0;
      inp_idx    <= '0;
      in_comment <= 1'b0;
      clr_addr   <= '0;
      scan_p     <= '0;
      scan_fwd   <= 1'b0;
      depth      <= '0;
      cur        <= '0;
    end else begin
      if (cmd.clr_step) clr_addr <= clr_addr + TA_W'(1);
      if (p_we) prog_len <= prog_len + PL_W'(1);
      if (i_we) inp_cnt <= inp_cnt + IL_W'(1);
      if (cmd.pc_inc) pc <= pc + PL_W'(1);
      if (cmd.exec_cmd) begin
        cur <= p_q;
        if (p_q == CH_RBRACE) in_comment <= 1'b0;
        else if (p_q == CH_LBRACE && sts.next_at_end) in_comment <= 1'b1;
        else if (live) begin
          unique case (p_q)
            CH_RIGHT: tp <= tp + TA_W'(1);
            CH_LEFT:  tp <= tp - TA_W'(1);
            CH_COMMA: if (inp_idx < inp_cnt) inp_idx <= inp_idx + IL_W'(1);
            default: ;
          endcase
        end
      end
      if (cmd.comment_la) in_comment <= p_q != CH_QUOTE;
      if (cmd.scan_start) begin
        scan_fwd <= cur == CH_OPEN;
        depth    <= (PL_W+1)'(1);
        // forward scan starts after '[', backward scan starts before ']'
        scan_p   <= (cur == CH_OPEN) ? pc : pc - PL_W'(2);
        if (cur == CH_OPEN && pc >= prog_len) pc <= prog_len;
        if (cur == CH_CLOSE && pc == PL_W'(1)) pc <= prog_len;
      end
      if (cmd.scan_step) begin
        if (scan_fwd) begin
          if (p_q == CH_OPEN) depth <= depth + (PL_W+1)'(1);
          else if (p_q == CH_CLOSE) depth <= depth - (PL_W+1)'(1);
          scan_p <= scan_p + PL_W'(1);
          if (sc_hit) pc <= scan_p + PL_W'(1);
          else if (sts.scan_done) pc <= prog_len;
        end else begin
          if (p_q == CH_CLOSE) depth <= depth + (PL_W+1)'(1);
          else if (p_q == CH_OPEN) depth <= depth - (PL_W+1)'(1);
          scan_p <= scan_p - PL_W'(1);
          if (sc_hit) pc <= scan_p;
          else if (sts.scan_done) pc <= prog_len;
        end
      end
    end
  end
endmodule

FILE: rtl/core/tmi_ctrl.sv
// controller state machine: sequences loads, execution, jumps and tape clear
// depends on tmi_pkg
module tmi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  output logic              out_load,
  input  logic              out_full,
  output tmi_pkg::tmi_cmd_t cmd,
  input  tmi_pkg::tmi_sts_t sts
);
  import tmi_pkg::*;

  typedef enum logic [6:0] {
    S_CLR   = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_LA    = 7'b0001000,
    S_SREQ  = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state, state_next;
  tmi_cmd_t base;
  logic scan_ph;

  always_comb begin
    base = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    state_next = state;
    unique case (state)
      S_CLR: begin
        base.clr_step = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = !out_full;
        if (in_valid && !out_full) begin
          if (func == FUNC_PROG) base.prog_wr = 1'b1;
          else if (func == FUNC_INP) base.inp_wr = 1'b1;
          else if (func == FUNC_EXEC) begin
            if (sts.pc_at_end) out_load = 1'b1;
            else state_next = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        base.exec_cmd = 1'b1;
        base.pc_inc = 1'b1;
        base.prog_rd_next = 1'b1;
        if (sts.is_lbrace && !sts.next_at_end) state_next = S_LA;
        else if (sts.is_jump) state_next = S_SREQ;
        else state_next = S_FIN;
      end
      S_LA: begin
        base.comment_la = 1'b1;
        state_next = S_FIN;
      end
      S_SREQ: begin
        base.scan_start = 1'b1;
        state_next = sts.scan_empty ? S_FIN : S_SCAN;
      end
      S_SCAN: begin
        base.prog_rd_scan = 1'b1;
        state_next = S_SCAN;
      end
      S_FIN: begin
        out_load = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // scan: one read issued, data arrives next cycle; alternate read and step
  always_comb begin
    cmd = base;
    if (state == S_SCAN) cmd.scan_step = scan_ph;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      scan_ph <= 1'b0;
    end else begin
      if (state == S_SCAN) begin
        scan_ph <= !scan_ph;
        if (scan_ph && sts.scan_done) state <= S_FIN;
      end else begin
        scan_ph <= 1'b0;
        state <= state_next;
      end
    end
  end
endmodule

FILE: rtl/core/tape_machine_interpreter.sv
// tape machine interpreter top level
// depends on tmi_pkg, tmi_if, tmi_ctrl, tmi_datapath
// loads and an execute at program end are handled in idle; other executes go exec,
// then la on '{' lookahead or sreq and scan on a bracket jump, then fin
// results sit in an output register; next word is taken once it drains
// after rst the tape is swept to zero cell by cell; no word is accepted then
module tape_machine_interpreter (
  input logic clk,
  input logic rst,
  tmi_in_if.sink    in_ch,
  tmi_out_if.source out_ch
);
  import tmi_pkg::*;

  tmi_cmd_t cmd;
  tmi_sts_t sts;
  logic out_load, emit, emit_q;
  logic [7:0] emit_byte, emit_byte_q;
  logic ready;

  tmi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(ready),
    .func(in_ch.func), .out_load(out_load), .out_full(out_ch.valid && !out_ch.ready),
    .cmd(cmd), .sts(sts));

  assign in_ch.ready = ready;

  tmi_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .data_byte(in_ch.data_byte),
    .sts(sts), .emit(emit), .emit_byte(emit_byte));

  // cleared once loaded so a halt answer carries no byte
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_q <= 1'b0;
      emit_byte_q <= 8'd0;
    end else if (cmd.exec_cmd) begin
      emit_q <= emit;
      emit_byte_q <= emit ? emit_byte : 8'd0;
    end else if (out_load) begin
      emit_q <= 1'b0;
      emit_byte_q <= 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (out_load) out_ch.valid <= 1'b1;
    else if (out_ch.ready) out_ch.valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.out_valid <= emit_q;
      out_ch.out_byte  <= emit_byte_q;
      out_ch.halted    <= sts.pc_at_end;
    end
  end
endmodule

FILE: rtl/core/tmi_checker.sv
// port-level checker for the tape machine interpreter, bound to the top level
// no dependencies
module tmi_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_out_valid,
  input logic [7:0] out_byte
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_out_valid |-> out_byte == 8'd0) else $error("stray byte");
  a_no_in_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("accept while full");
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid) else $error("word withdrawn");
  a_rst_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("result after reset");
endmodule

bind tape_machine_interpreter tmi_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_out_valid(out_ch.out_valid), .out_byte(out_ch.out_byte));

FILE: test/tape_machine_interpreter_tb.sv
// testbench for tape_machine_interpreter: loads programs and input bytes, runs them step by step
// and checks every result against an in-bench model; depends on tmi_pkg and tmi_if
module tape_machine_interpreter_tb;
  import tmi_pkg::*;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       halted;
  } step_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  tmi_in_if  in_ch();
  tmi_out_if out_ch();

  tape_machine_interpreter dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always #6 clk = ~clk;

  // model state
  logic [7:0]    prog_mem [PROG_DEPTH];
  logic [PL_W-1:0] prog_len;
  logic [PL_W-1:0] pc;
  logic [7:0]    tape [TAPE_DEPTH];
  logic [TA_W-1:0] tp;
  logic [7:0]    inp_mem [INPUT_DEPTH];
  logic [IL_W-1:0] inp_cnt;
  logic [IL_W-1:0] inp_rd;
  logic          in_cmt;

  step_res_t expected_steps[$];
  int mismatches = 0;
  longint cycles = 0;
  bit done = 0;

  function automatic void jump_fwd();
    int depth;
    int p;
    depth = 1;
    p = int'(pc);
    while (p < prog_len) begin
      if (prog_mem[p] == CH_OPEN) depth++;
      else if (prog_mem[p] == CH_CLOSE) begin
        depth--;
        if (depth == 0) begin
          pc = PL_W'(p + 1);
          return;
        end
      end
      p++;
    end
    pc = prog_len;
  endfunction

  function automatic void jump_bwd(int close_pos);
    int depth;
    int p;
    depth = 1;
    p = close_pos;
    while (p > 0) begin
      p--;
      if (prog_mem[p] == CH_CLOSE) depth++;
      else if (prog_mem[p] == CH_OPEN) begin
        depth--;
        if (depth == 0) begin
          pc = PL_W'(p);
          return;
        end
      end
    end
    pc = prog_len;
  endfunction

  function automatic void predict_word(logic [1:0] f, logic [7:0] b);
    step_res_t r;
    int pos;
    logic [7:0] c;
    r = '0;
    if (f == FUNC_PROG) begin
      if (prog_len < PROG_DEPTH) begin
        prog_mem[prog_len] = b;
        prog_len++;
      end
      return;
    end
    if (f == FUNC_INP) begin
      if (inp_cnt < INPUT_DEPTH) begin
        inp_mem[inp_cnt] = b;
        inp_cnt++;
      end
      return;
    end
    if (f != FUNC_EXEC) return;
    if (pc >= prog_len) begin
      r.halted = 1'b1;
      expected_steps.push_back(r);
      return;
    end
    pos = int'(pc);
    c = prog_mem[pos];
    pc = PL_W'(pos + 1);
    if (c == CH_LBRACE) in_cmt = !(pc < prog_len && prog_mem[pc] == CH_QUOTE);
    else if (c == CH_RBRACE) in_cmt = 1'b0;
    else if (!in_cmt) begin
      case (c)
        CH_RIGHT: tp = tp + TA_W'(1);
        CH_LEFT:  tp = tp - TA_W'(1);
        CH_PLUS:  tape[tp] = tape[tp] + 8'd1;
        CH_MINUS: tape[tp] = tape[tp] - 8'd1;
        CH_DOT: begin
          r.out_valid = 1'b1;
          r.out_byte = tape[tp];
        end
        CH_COMMA: begin
          if (inp_rd < inp_cnt) begin
            tape[tp] = inp_mem[inp_rd[IA_W-1:0]];
            inp_rd++;
          end else tape[tp] = 8'd0;
        end
        CH_OPEN:  if (tape[tp] == 8'd0) jump_fwd();
        CH_CLOSE: if (tape[tp] != 8'd0) jump_bwd(pos);
        default: ;
      endcase
    end
    r.halted = (pc >= prog_len);
    expected_steps.push_back(r);
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_PROG;
    in_ch.data_byte = 8'd0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 10000000 && !done) begin
      $display("tape_machine_interpreter regression: fail");
      $finish;
    end
  end

  // result checker with random back pressure
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_steps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %0b/%02h/%0b",
            out_ch.out_valid, out_ch.out_byte, out_ch.halted);
        end else begin
          step_res_t e;
          e = expected_steps.pop_front();
          if (e.out_valid !== out_ch.out_valid || e.out_byte !== out_ch.out_byte ||
              e.halted !== out_ch.halted) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %0b/%02h/%0b got %0b/%02h/%0b",
              e.out_valid, e.out_byte, e.halted,
              out_ch.out_valid, out_ch.out_byte, out_ch.halted);
          end
        end
      end
      out_ch.ready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
    end
  end

  // valid stays up after an accept unless a gap follows; the caller drops it at the end
  task automatic send_word(logic [1:0] f, logic [7:0] b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_word(f, b);
  endtask

  function automatic logic [7:0] rand_cmd();
    logic [7:0] cmds [10];
    cmds = '{CH_RIGHT, CH_LEFT, CH_PLUS, CH_MINUS, CH_DOT, CH_COMMA, CH_OPEN, CH_CLOSE,
             CH_LBRACE, CH_RBRACE};
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    if ($urandom_range(0, 19) == 0) return CH_QUOTE;
    return cmds[$urandom_range(0, 9)];
  endfunction

  task automatic run_steps(int n);
    repeat (n) send_word(FUNC_EXEC, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_directed();
    send_word(FUNC_EXEC, 8'hFF);             // execute with empty program
    send_word(FUNC_NONE, 8'hA5);             // unused func
    send_word(FUNC_INP, 8'hFF);
    send_word(FUNC_INP, 8'h00);
    send_word(FUNC_PROG, CH_LEFT);           // move left of the centre start cell
    send_word(FUNC_PROG, CH_MINUS);
    send_word(FUNC_PROG, CH_DOT);
    send_word(FUNC_PROG, CH_COMMA);
    send_word(FUNC_PROG, CH_DOT);
    send_word(FUNC_PROG, CH_COMMA);
    send_word(FUNC_PROG, CH_COMMA);          // input exhausted
    send_word(FUNC_PROG, CH_PLUS);
    send_word(FUNC_PROG, CH_OPEN);
    send_word(FUNC_PROG, CH_MINUS);
    send_word(FUNC_PROG, CH_CLOSE);
    send_word(FUNC_PROG, CH_LBRACE);
    send_word(FUNC_PROG, CH_QUOTE);
    send_word(FUNC_PROG, CH_LBRACE);
    send_word(FUNC_PROG, CH_DOT);
    send_word(FUNC_PROG, CH_RBRACE);
    send_word(FUNC_PROG, 8'h00);
    send_word(FUNC_PROG, CH_RIGHT);
    send_word(FUNC_PROG, CH_CLOSE);          // unmatched close with zero cell: falls through
    send_word(FUNC_PROG, CH_OPEN);           // unmatched open halts
    run_steps(30);
  endtask

  task automatic test_random_programs();
    int total;
    total = 0;
    while (total < 600) begin
      int plen;
      plen = $urandom_range(4, 40);
      repeat ($urandom_range(0, 4)) begin
        send_word(FUNC_INP, 8'($urandom_range(0, 255)));
        total++;
      end
      repeat (plen) begin
        send_word(FUNC_PROG, rand_cmd());
        total++;
      end
      repeat ($urandom_range(plen / 2, plen * 2)) begin
        send_word(($urandom_range(0, 15) == 0) ? FUNC_NONE : FUNC_EXEC,
                  8'($urandom_range(0, 255)));
        total++;
      end
    end
  endtask

  task automatic test_store_full();
    // fill the input store past capacity, then read from it
    while (inp_cnt < INPUT_DEPTH + 2) begin
      send_word(FUNC_INP, 8'($urandom_range(0, 255)));
      if (inp_cnt == INPUT_DEPTH) begin
        send_word(FUNC_INP, 8'h11);
        send_word(FUNC_INP, 8'h22);
        break;
      end
    end
    send_word(FUNC_PROG, CH_COMMA);
    send_word(FUNC_PROG, CH_DOT);
    run_steps(150);
  endtask

  initial begin
    prog_len = '0;
    pc = '0;
    tp = TA_W'(TAPE_DEPTH / 2);
    inp_cnt = '0;
    inp_rd = '0;
    in_cmt = 1'b0;
    foreach (tape[i]) tape[i] = 8'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_programs();
    test_store_full();
    in_ch.valid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    done = 1;
    if (mismatches == 0 && expected_steps.size() == 0)
      $display("tape_machine_interpreter regression: pass");
    else
      $display("tape_machine_interpreter regression: fail");
    $finish;
  end
endmodule
